FILE: rtl/fdu_pkg.sv
package fdu_pkg;

  // Register numbers inside the drive window.
  localparam logic [3:0] REG_STATUS  = 4'd0;
  localparam logic [3:0] REG_COMMAND = 4'd1;
  localparam logic [3:0] REG_ADDRESS = 4'd2;
  localparam logic [3:0] REG_DATA    = 4'd3;
  localparam logic [3:0] REG_SEED_LO = 4'd8;
  localparam logic [3:0] REG_SEED_HI = 4'd9;
  localparam logic [3:0] REG_ARM     = 4'd15;

  // Access kinds.
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Challenge arming sequence codes.
  localparam logic [1:0] ARM_IDLE  = 2'd0;
  localparam logic [1:0] ARM_ONE   = 2'd1;
  localparam logic [1:0] ARM_READY = 2'd2;

  // Fixed values.
  localparam logic [15:0] SEED_RESET  = 16'hFFF0;
  localparam logic [7:0]  STATUS_BASE = 8'h43;
  localparam logic [7:0]  ADDRESS_RD  = 8'hFF;
  // Low 15 bits of the response polynomial 0x8FAF.
  localparam logic [14:0] RESP_POLY   = 15'h0FAF;

  typedef struct packed {
    logic        func;
    logic [3:0]  reg_index;
    logic [15:0] write_value;
    logic        card_is_flash;
    logic        card_readonly;
    logic        busy_transfer;
    logic        ser_busy;
    logic        cmd_busy;
    logic [7:0]  card_byte_in;
  } in_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic        card_read_strobe;
    logic        card_write_strobe;
    logic [7:0]  card_byte_out;
    logic        command_latch;
    logic        address_latch;
    logic [2:0]  mode_bits;
  } out_t;

  // Shifts four seed bits, most significant first, into the remainder register.
  function automatic logic [14:0] resp_step4(logic [14:0] rem, logic [3:0] bits);
    logic [14:0] r;
    logic        fb;
    r = rem;
    for (int i = 3; i >= 0; i--) begin
      fb = r[14] ^ bits[i];
      r  = {r[13:0], 1'b0} ^ (fb ? RESP_POLY : 15'd0);
    end
    return r;
  endfunction

endpackage

FILE: rtl/flash_drive_unlock_registers.sv
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-----------------------
// in       | input     | in_valid_i / in_stall_o    | in_data_i  (in_t)
// out      | output    | out_valid_o / out_stall_i  | out_data_o (out_t)
// cfg      | input     | cfg_we_i                   | cfg_data_i (seed)
//
// One transaction enters per cycle unless input is stalled; its result appears
// in the output register on the next cycle. The output register decouples the
// sides: a new input transaction is taken when the output is empty or being
// drained and no rebuild runs. After reset and after every seed write the
// response remainder is rebuilt four seed bits per cycle; input stalls meanwhile.
// Reset clears the unlock bits, the arming sequence and the mode bits.
module flash_drive_unlock_registers (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fdu_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output fdu_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_data_i
);
  import fdu_pkg::*;

  logic [15:0] seed_q;
  logic [14:0] rem_q, rem_d;
  logic        busy_q;
  logic [1:0]  cnt_q;
  logic [3:0]  nibble;

  logic [1:0]  unlock_q, unlock_d;
  logic [1:0]  arm_q, arm_d;
  logic [2:0]  mode_q, mode_d;

  logic        out_valid_q;
  out_t        out_q, res;
  logic        in_accept;
  logic        unlocked, armed;
  logic [15:0] resp;

  // Input is taken when the response is ready and the output register frees up.
  assign in_stall_o = busy_q | (out_valid_q & out_stall_i);
  assign in_accept  = in_valid_i & ~in_stall_o;

  // Seed nibble for the current remainder step, most significant first.
  always_comb begin
    unique case (cnt_q)
      2'd0:    nibble = seed_q[15:12];
      2'd1:    nibble = seed_q[11:8];
      2'd2:    nibble = seed_q[7:4];
      default: nibble = seed_q[3:0];
    endcase
  end

  assign rem_d = resp_step4(rem_q, nibble);

  // Response: 15-bit remainder on top, odd parity in bit 0.
  assign resp = {rem_q, ~(^rem_q)};

  // Seed register and the remainder sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
      rem_q  <= '0;
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_data_i;
      rem_q  <= '0;
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      cnt_q <= cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign unlocked = (unlock_q == 2'b11);
  assign armed    = (arm_q == ARM_READY);

  // Register access decode and next state.
  always_comb begin
    res      = '0;
    unlock_d = unlock_q;
    arm_d    = arm_q;
    mode_d   = mode_q;
    if (in_data_i.func == FUNC_READ) begin
      priority if (unlocked && in_data_i.reg_index == REG_STATUS) begin
        res.read_value = {8'd0, STATUS_BASE | {in_data_i.cmd_busy, 1'b0,
                          in_data_i.ser_busy, in_data_i.busy_transfer,
                          in_data_i.card_readonly, ~in_data_i.card_is_flash, 2'b00}};
      end else if (unlocked && in_data_i.reg_index == REG_COMMAND) begin
        res.read_value = {13'd0, in_data_i.card_is_flash, 2'b00};
      end else if (unlocked && in_data_i.reg_index == REG_ADDRESS) begin
        res.read_value = {8'd0, ADDRESS_RD};
      end else if (unlocked && in_data_i.reg_index == REG_DATA) begin
        res.read_value       = {8'd0, in_data_i.card_byte_in};
        res.card_read_strobe = 1'b1;
      end else if (armed && in_data_i.reg_index == REG_SEED_LO) begin
        res.read_value = {8'd0, seed_q[7:0]};
      end else if (armed && in_data_i.reg_index == REG_SEED_HI) begin
        res.read_value = {8'd0, seed_q[15:8]};
      end else begin
        res.read_value = '0;
      end
    end else begin
      priority if (unlocked && in_data_i.reg_index == REG_STATUS) begin
        mode_d = in_data_i.write_value[7:5];
      end else if (unlocked && (in_data_i.reg_index == REG_COMMAND ||
                   in_data_i.reg_index == REG_ADDRESS ||
                   in_data_i.reg_index == REG_DATA)) begin
        res.card_write_strobe = 1'b1;
        res.card_byte_out     = in_data_i.write_value[7:0];
        res.command_latch     = (in_data_i.reg_index == REG_COMMAND);
        res.address_latch     = (in_data_i.reg_index == REG_ADDRESS);
      end else if (in_data_i.reg_index == REG_SEED_LO) begin
        if (armed && resp[7:0] == in_data_i.write_value[7:0]) begin
          unlock_d[0] = 1'b1;
        end
      end else if (in_data_i.reg_index == REG_SEED_HI) begin
        if (armed && resp[15:8] == in_data_i.write_value[7:0]) begin
          unlock_d[1] = 1'b1;
        end
      end else if (in_data_i.reg_index == REG_ARM) begin
        priority if (in_data_i.write_value == 16'd1 && arm_q == ARM_IDLE) begin
          arm_d = ARM_ONE;
        end else if (in_data_i.write_value == 16'd0 && arm_q == ARM_ONE) begin
          arm_d = ARM_READY;
        end else begin
          arm_d = ARM_IDLE;
        end
      end else begin
        mode_d = mode_q;
      end
    end
    res.mode_bits = mode_d;
  end

  // Drive state, updated once per accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unlock_q <= '0;
      arm_q    <= ARM_IDLE;
      mode_q   <= '0;
    end else if (in_accept) begin
      unlock_q <= unlock_d;
      arm_q    <= arm_d;
      mode_q   <= mode_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/fdu_checker.sv
module fdu_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input fdu_pkg::out_t out_data_o,
  input logic          cfg_we_i
);
  import fdu_pkg::*;

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result transaction keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // A seed write blocks input while the response is rebuilt.
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("input not stalled after seed write");

  // Latch flags and the card byte only come with a write to the card.
  a_latch_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.card_write_strobe |->
      !out_data_o.command_latch && !out_data_o.address_latch &&
      out_data_o.card_byte_out == 8'd0)
    else $error("latch or card byte without write strobe");

endmodule

bind flash_drive_unlock_registers fdu_checker u_fdu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_we_i    (cfg_we_i)
);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import fdu_pkg::*;

  // Registers with no function in the drive window.
  localparam logic [3:0] REG_UNUSED_LOW  = 4'd7;
  localparam logic [3:0] REG_UNUSED_HIGH = 4'd14;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_data_i  = '0;

  // Bus accesses waiting to be driven and replies the drive owes.
  in_t  pending_accesses[$];
  out_t predicted_replies[$];
  out_t want_reply;

  // Own copy of the drive state, updated at each accepted transaction.
  logic [15:0] drv_seed   = SEED_RESET;
  logic [1:0]  drv_unlock = 2'b00;
  logic [1:0]  drv_arm    = ARM_IDLE;
  logic [2:0]  drv_mode   = 3'd0;

  // Seed as seen by the stimulus, and stimulus shaping flags.
  logic [15:0] stim_seed   = SEED_RESET;
  bit          keep_locked = 1'b1;
  bit          steady_flow = 1'b0;
  int          fault_count = 0;

  flash_drive_unlock_registers u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Expected response: seed times x^15 reduced by the polynomial, with an odd parity bit.
  function automatic logic [15:0] unlock_response(logic [15:0] seed);
    logic [30:0] rem;
    logic [30:0] divisor;
    rem     = {seed, 15'd0};
    divisor = {1'b1, RESP_POLY, 15'd0};
    for (int k = 30; k >= 15; k--) begin
      if (rem[k]) begin
        rem = rem ^ (divisor >> (30 - k));
      end
    end
    return {rem[14:0], ~^rem[14:0]};
  endfunction

  // Works out the reply of one bus access and advances the drive state.
  function automatic out_t drive_access(in_t acc);
    out_t        r;
    logic        unlocked;
    logic        armed;
    logic [15:0] resp;
    r        = '0;
    unlocked = (drv_unlock == 2'b11);
    armed    = (drv_arm == ARM_READY);
    resp     = unlock_response(drv_seed);
    if (acc.func == FUNC_READ) begin
      if (unlocked && acc.reg_index == REG_STATUS) begin
        r.read_value = {8'h00, STATUS_BASE | {acc.cmd_busy, 1'b0, acc.ser_busy,
                        acc.busy_transfer, acc.card_readonly, ~acc.card_is_flash, 2'b00}};
      end else if (unlocked && acc.reg_index == REG_COMMAND) begin
        r.read_value = {13'd0, acc.card_is_flash, 2'b00};
      end else if (unlocked && acc.reg_index == REG_ADDRESS) begin
        r.read_value = {8'h00, ADDRESS_RD};
      end else if (unlocked && acc.reg_index == REG_DATA) begin
        r.read_value       = {8'h00, acc.card_byte_in};
        r.card_read_strobe = 1'b1;
      end else if (acc.reg_index == REG_SEED_LO && armed) begin
        r.read_value = {8'h00, drv_seed[7:0]};
      end else if (acc.reg_index == REG_SEED_HI && armed) begin
        r.read_value = {8'h00, drv_seed[15:8]};
      end
    end else begin
      if (unlocked && acc.reg_index == REG_STATUS) begin
        drv_mode = acc.write_value[7:5];
      end else if (unlocked && acc.reg_index >= REG_COMMAND && acc.reg_index <= REG_DATA) begin
        r.card_write_strobe = 1'b1;
        r.card_byte_out     = acc.write_value[7:0];
        r.command_latch     = (acc.reg_index == REG_COMMAND);
        r.address_latch     = (acc.reg_index == REG_ADDRESS);
      end else if (acc.reg_index == REG_SEED_LO) begin
        if (armed && resp[7:0] == acc.write_value[7:0]) drv_unlock[0] = 1'b1;
      end else if (acc.reg_index == REG_SEED_HI) begin
        if (armed && resp[15:8] == acc.write_value[7:0]) drv_unlock[1] = 1'b1;
      end else if (acc.reg_index == REG_ARM) begin
        if (acc.write_value == 16'd1 && drv_arm == ARM_IDLE) drv_arm = ARM_ONE;
        else if (acc.write_value == 16'd0 && drv_arm == ARM_ONE) drv_arm = ARM_READY;
        else drv_arm = ARM_IDLE;
      end
    end
    r.mode_bits = drv_mode;
    return r;
  endfunction

  // Builds one access with random card inputs. While the drive is meant to stay
  // locked, a high response byte that would unlock it is spoiled.
  function automatic in_t make_access(logic func, logic [3:0] idx, logic [15:0] val);
    in_t         acc;
    logic [15:0] resp;
    resp              = unlock_response(stim_seed);
    acc.func          = func;
    acc.reg_index     = idx;
    acc.write_value   = val;
    acc.card_is_flash = 1'($urandom_range(0, 1));
    acc.card_readonly = 1'($urandom_range(0, 1));
    acc.busy_transfer = 1'($urandom_range(0, 1));
    acc.ser_busy      = 1'($urandom_range(0, 1));
    acc.cmd_busy      = 1'($urandom_range(0, 1));
    acc.card_byte_in  = 8'($urandom_range(0, 255));
    if (keep_locked && func == FUNC_WRITE && idx == REG_SEED_HI && val[7:0] == resp[15:8]) begin
      acc.write_value[0] = ~val[0];
    end
    return acc;
  endfunction

  task automatic queue_access(input logic func, input logic [3:0] idx, input logic [15:0] val);
    pending_accesses.push_back(make_access(func, idx, val));
  endtask

  // Arming sequence: write 1 then 0 to the arm register.
  task automatic queue_arm();
    queue_access(FUNC_WRITE, REG_ARM, 16'd1);
    queue_access(FUNC_WRITE, REG_ARM, 16'd0);
  endtask

  // Random traffic, weighted toward arming, challenge accesses and the card registers.
  task automatic queue_random(input int count);
    int          sel;
    logic [15:0] resp;
    logic [15:0] val;
    logic [3:0]  idx;
    resp = unlock_response(stim_seed);
    repeat (count) begin
      sel = $urandom_range(0, 99);
      val = 16'($urandom_range(0, 65535));
      if (sel < 15) begin
        queue_arm();
        if ($urandom_range(0, 1)) queue_access(FUNC_READ, REG_SEED_LO, val);
        if ($urandom_range(0, 1)) queue_access(FUNC_READ, REG_SEED_HI, val);
      end else if (sel < 32) begin
        idx = $urandom_range(0, 1) ? REG_SEED_LO : REG_SEED_HI;
        if ($urandom_range(0, 1)) val[7:0] = (idx == REG_SEED_LO) ? resp[7:0] : resp[15:8];
        queue_access($urandom_range(0, 3) != 0 ? FUNC_WRITE : FUNC_READ, idx, val);
      end else if (sel < 80) begin
        idx = 4'($urandom_range(REG_STATUS, REG_DATA));
        queue_access(1'($urandom_range(0, 1)), idx, val);
      end else begin
        if ($urandom_range(0, 3) == 0) val = 16'($urandom_range(0, 2));
        queue_access(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), val);
      end
    end
  endtask

  // Waits until no transaction is queued, in flight or owed.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_accesses.size() != 0 || in_valid_i || predicted_replies.size() != 0 ||
           out_valid_o);
  endtask

  // Writes the seed register while the drive is idle.
  task automatic load_seed(input logic [15:0] seed);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= seed;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    stim_seed = seed;
    @(negedge clk_i);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fault_count++;
    end
  endtask

  // Driver: predicts each accepted transaction and presents the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) drv_seed = cfg_data_i;
      if (in_valid_i && !in_stall_o) predicted_replies.push_back(drive_access(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_accesses.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 18)) begin
          in_data_i  <= pending_accesses.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted reply against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_replies.size() == 0) begin
          $error("reply with no access outstanding: 0x%0h", out_data_o);
          fault_count++;
        end else begin
          want_reply = predicted_replies.pop_front();
          compare_field("read_value", want_reply.read_value, out_data_o.read_value);
          compare_field("card_read_strobe", 16'(want_reply.card_read_strobe),
                        16'(out_data_o.card_read_strobe));
          compare_field("card_write_strobe", 16'(want_reply.card_write_strobe),
                        16'(out_data_o.card_write_strobe));
          compare_field("card_byte_out", 16'(want_reply.card_byte_out),
                        16'(out_data_o.card_byte_out));
          compare_field("command_latch", 16'(want_reply.command_latch),
                        16'(out_data_o.command_latch));
          compare_field("address_latch", 16'(want_reply.address_latch),
                        16'(out_data_o.address_latch));
          compare_field("mode_bits", 16'(want_reply.mode_bits), 16'(out_data_o.mode_bits));
        end
      end
      out_stall_i <= !steady_flow && ($urandom_range(0, 99) < 18);
    end
  end

  // Stimulus sequence.
  initial begin
    in_t         acc;
    logic [15:0] resp;

    // Locked drive: card registers read zero and ignore writes.
    queue_access(FUNC_READ, REG_STATUS, 16'd0);
    queue_access(FUNC_READ, REG_DATA, 16'd0);
    queue_access(FUNC_READ, REG_UNUSED_LOW, 16'd0);
    queue_access(FUNC_WRITE, REG_STATUS, 16'hFFFF);
    queue_access(FUNC_WRITE, REG_ADDRESS, 16'h00FF);
    // Challenge registers before arming, and broken arming sequences.
    resp = unlock_response(stim_seed);
    queue_access(FUNC_READ, REG_SEED_LO, 16'd0);
    queue_access(FUNC_WRITE, REG_SEED_LO, {8'h00, resp[7:0]});
    queue_access(FUNC_WRITE, REG_ARM, 16'd1);
    queue_access(FUNC_WRITE, REG_ARM, 16'd5);
    queue_access(FUNC_WRITE, REG_ARM, 16'd0);
    // Armed: seed reads, a wrong byte, then only the low response byte.
    queue_arm();
    queue_access(FUNC_READ, REG_SEED_LO, 16'd0);
    queue_access(FUNC_READ, REG_SEED_HI, 16'd0);
    queue_access(FUNC_WRITE, REG_SEED_HI, {8'h00, ~resp[15:8]});
    queue_access(FUNC_WRITE, REG_SEED_LO, {8'h00, resp[7:0]});
    queue_access(FUNC_READ, REG_STATUS, 16'd0);
    queue_access(FUNC_READ, REG_ARM, 16'd0);
    queue_access(FUNC_WRITE, REG_UNUSED_HIGH, 16'hFFFF);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_random(70);
    load_seed(16'h0000);
    queue_random(40);
    load_seed(16'hFFFF);
    queue_random(40);

    // Full unlock, then the card registers at their extremes.
    wait_idle();
    keep_locked = 1'b0;
    resp = unlock_response(stim_seed);
    queue_arm();
    queue_access(FUNC_WRITE, REG_SEED_LO, {8'h00, resp[7:0]});
    queue_access(FUNC_WRITE, REG_SEED_HI, {8'hFF, resp[15:8]});
    acc = make_access(FUNC_READ, REG_STATUS, 16'd0);
    acc.card_is_flash = 1'b0;
    acc.card_readonly = 1'b1;
    acc.busy_transfer = 1'b1;
    acc.ser_busy      = 1'b1;
    acc.cmd_busy      = 1'b1;
    pending_accesses.push_back(acc);
    acc.card_is_flash = 1'b1;
    acc.card_readonly = 1'b0;
    acc.busy_transfer = 1'b0;
    acc.ser_busy      = 1'b0;
    acc.cmd_busy      = 1'b0;
    pending_accesses.push_back(acc);
    queue_access(FUNC_READ, REG_COMMAND, 16'd0);
    queue_access(FUNC_READ, REG_ADDRESS, 16'd0);
    acc = make_access(FUNC_READ, REG_DATA, 16'd0);
    acc.card_byte_in = 8'hFF;
    pending_accesses.push_back(acc);
    queue_access(FUNC_WRITE, REG_STATUS, 16'hFFFF);
    queue_access(FUNC_WRITE, REG_COMMAND, 16'hFF00);
    queue_access(FUNC_WRITE, REG_DATA, 16'h00FF);
    queue_access(FUNC_WRITE, REG_STATUS, 16'd0);

    // Back-to-back traffic with neither side holding off.
    steady_flow = 1'b1;
    queue_random(70);
    wait_idle();
    steady_flow = 1'b0;

    load_seed(16'($urandom_range(0, 65535)));
    queue_random(80);

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
